@@ sv/dns_name_validator_defines.svh @@
// Assertion macros shared by the name validator RTL.
`ifndef DNS_NAME_VALIDATOR_DEFINES_SVH
`define DNS_NAME_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define DNV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dns_name_validator: assertion failed");
// Checked on every rising clock edge, reset included.
`define DNV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dns_name_validator: assertion failed");
`else
`define DNV_ASSERT(lbl, prop)
`define DNV_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/dnv_pkg.sv @@
// Types, constants and helper functions for the DNS name validator.
`timescale 1ns / 1ps
`default_nettype none
package dnv_pkg;

  // status codes
  localparam logic [2:0] ST_VALID       = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR    = 3'd2;
  localparam logic [2:0] ST_LEADING_DOT = 3'd3;
  localparam logic [2:0] ST_LONE_DOT    = 3'd4;
  localparam logic [2:0] ST_DOUBLE_DOT  = 3'd5;
  localparam logic [2:0] ST_BAD_LABEL   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_NAME  = 2'd0;
  localparam logic [1:0] CFG_MAX_LABEL = 2'd1;

  localparam logic [7:0] MAX_NAME_RESET  = 8'd255;
  localparam logic [5:0] MAX_LABEL_RESET = 6'd63;

  localparam logic [8:0] NAME_SAT   = 9'd511;
  localparam logic [6:0] LABEL_SAT  = 7'd127;
  localparam logic [2:0] PREFIX_LEN = 3'd4;
  localparam logic [8:0] SHORT_LIMIT = 9'd4;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_N     = 8'h6E;

  typedef struct packed {
    logic [8:0] name_len;
    logic [6:0] label_len;
    logic       prev_dot;
    logic       first_dot;
    logic       bad_char;
    logic [2:0] scan_err;
    logic       top_bad;
    logic [2:0] prefix;
    logic [8:0] top_start;
  } dnv_state_t;

  localparam dnv_state_t STATE_CLEAR = '0;

  function automatic logic valid_byte(input logic [7:0] c);
    logic ok;
    ok = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
         (c == CH_DOT) || (c == CH_DASH) || (c == CH_UNDER);
    return ok;
  endfunction

  // digit, hyphen or underscore
  function automatic logic label_char_bad(input logic [7:0] c);
    logic bad;
    bad = (c inside {[8'h30:8'h39]}) || (c == CH_DASH) || (c == CH_UNDER);
    return bad;
  endfunction

  // expected character at each position of the "xn--" prefix
  function automatic logic [7:0] xn_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_X;
      2'd1:    c = CH_N;
      default: c = CH_DASH;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] judge(input dnv_state_t s,
                                       input logic [7:0] max_name,
                                       input logic [5:0] max_label);
    logic [2:0] st;
    if (s.name_len == 9'd0 || s.name_len > {1'b0, max_name}) begin
      st = ST_BAD_LENGTH;
    end else if (s.bad_char) begin
      st = ST_BAD_CHAR;
    end else if (s.first_dot) begin
      st = (s.name_len != 9'd1) ? ST_LEADING_DOT : ST_LONE_DOT;
    end else if (s.scan_err != ST_VALID) begin
      st = s.scan_err;
    end else if (s.label_len > {1'b0, max_label}) begin
      st = ST_BAD_LABEL;
    end else if (s.top_start > SHORT_LIMIT && s.prefix == PREFIX_LEN) begin
      st = ST_VALID;
    end else if (s.top_bad) begin
      st = ST_BAD_LABEL;
    end else begin
      st = ST_VALID;
    end
    return st;
  endfunction

endpackage
`default_nettype wire

@@ sv/dnv_scan.sv @@
// Per-name scan state: counters and flags updated by each character word.
`timescale 1ns / 1ps
`default_nettype none
module dnv_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        char_code,
  input  wire logic              last,
  input  wire logic              empty_name,
  input  wire logic [5:0]        max_label_length,
  output dnv_pkg::dnv_state_t    taken,
  output logic                   done
);
  import dnv_pkg::*;

`include "dns_name_validator_defines.svh"

  dnv_state_t state;
  dnv_state_t state_next;
  logic [8:0] next_len;

  assign done = empty_name | last;

  // state as it stands once the current word's character is counted
  always_comb begin
    next_len = (state.name_len == NAME_SAT) ? NAME_SAT : state.name_len + 9'd1;
    taken = state;
    if (!empty_name) begin
      if (state.name_len == 9'd0 && char_code == CH_DOT) begin
        taken.first_dot = 1'b1;
      end
      if (!valid_byte(char_code)) begin
        taken.bad_char = 1'b1;
      end
      if (char_code == CH_DOT) begin
        if (state.scan_err == ST_VALID) begin
          if (state.prev_dot) begin
            taken.scan_err = ST_DOUBLE_DOT;
          end else if (state.label_len > {1'b0, max_label_length}) begin
            taken.scan_err = ST_BAD_LABEL;
          end
        end
        taken.label_len = 7'd0;
        taken.prefix    = 3'd0;
        taken.top_bad   = 1'b0;
        taken.top_start = next_len;
        taken.prev_dot  = 1'b1;
      end else begin
        // prefix only advances while every character so far has matched
        if (state.prefix < PREFIX_LEN &&
            state.label_len == {4'd0, state.prefix} &&
            char_code == xn_char(state.prefix[1:0])) begin
          taken.prefix = state.prefix + 3'd1;
        end
        if (label_char_bad(char_code)) begin
          taken.top_bad = 1'b1;
        end
        taken.label_len = (state.label_len == LABEL_SAT) ?
                          LABEL_SAT : state.label_len + 7'd1;
        taken.prev_dot = 1'b0;
      end
      taken.name_len = next_len;
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = done ? STATE_CLEAR : taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `DNV_ASSERT(a_prefix_range, state.prefix <= PREFIX_LEN)
  `DNV_ASSERT(a_prefix_in_label, {4'd0, state.prefix} <= state.label_len)
  `DNV_ASSERT(a_start_in_name, state.top_start <= state.name_len)

endmodule
`default_nettype wire

@@ sv/dnv_result_buf.sv @@
// Output register with one skid entry for status words.
`timescale 1ns / 1ps
`default_nettype none
module dnv_result_buf (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [2:0] push_status,
  output logic            can_push,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [2:0]      status
);

`include "dns_name_validator_defines.svh"

  logic       out_valid;
  logic       out_valid_next;
  logic [2:0] out_data;
  logic       skid_valid;
  logic       skid_valid_next;
  logic [2:0] skid_data;
  logic       pop;

  assign pop          = out_valid & result_ready;
  assign can_push     = ~skid_valid;
  assign result_valid = out_valid;
  assign status       = out_data;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (skid_valid) begin
      if (pop) begin
        skid_valid_next = 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid_next = 1'b1;
      end else begin
        out_valid_next = 1'b1;
      end
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_status;
      end else begin
        out_data <= push_status;
      end
    end
  end

  `DNV_ASSERT(a_skid_behind_out, skid_valid |-> out_valid)
  `DNV_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_valid))

endmodule
`default_nettype wire

@@ sv/dns_name_validator.sv @@
// DNS name validator: one char word in per cycle while ready, one status word per name.
// Status is registered when the final word (last or empty_name) is taken.
// Throughput: one character word per cycle while the skid entry is free.
// A one-entry skid behind the output register keeps input flowing while a status waits.
// Reset clears the scan state and result buffer; limits return to 255 and 63.
`timescale 1ns / 1ps
`default_nettype none
module dns_name_validator (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  input  wire logic       empty_name,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [2:0]      status
);
  import dnv_pkg::*;

  logic [7:0] max_name_length;
  logic [5:0] max_label_length;
  logic       accept;
  logic       done;
  logic       can_push;
  logic [2:0] status_calc;
  dnv_state_t taken;

  assign cfg_ready  = 1'b1;
  assign item_ready = can_push;
  assign accept     = item_valid & item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length  <= MAX_NAME_RESET;
      max_label_length <= MAX_LABEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_NAME:  max_name_length  <= cfg_data;
        CFG_MAX_LABEL: max_label_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  dnv_scan u_scan (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .char_code        (char_code),
    .last             (last),
    .empty_name       (empty_name),
    .max_label_length (max_label_length),
    .taken            (taken),
    .done             (done)
  );

  assign status_calc = judge(taken, max_name_length, max_label_length);

  dnv_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept & done),
    .push_status  (status_calc),
    .can_push     (can_push),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status)
  );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the DNS name validator: directed names, then random names.
module tb_top;
  import dnv_pkg::*;

  typedef enum int {END_LAST, END_EMPTY, END_BOTH} tail_e;

  localparam int NO_PIN = -1;
  localparam int RANDOM_ITEMS = 450;
  localparam int PHASES = 9;
  localparam int ROWS = 11;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_MAX_NAME;
  logic [7:0] cfg_data = '0;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] char_code = '0;
  logic       last = 1'b0;
  logic       empty_name = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [2:0] status;

  dns_name_validator dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .char_code(char_code),
    .last(last),
    .empty_name(empty_name),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // scan state of the name in progress, as the block should hold it
  typedef struct packed {
    logic [8:0] seen;
    logic [6:0] run;
    logic       prev_dot;
    logic       lead_dot;
    logic       junk;
    logic [2:0] scan_fault;
    logic       tail_bad;
    logic [2:0] xn_hits;
    logic [8:0] tail_pos;
  } name_scan_t;

  name_scan_t scan;
  logic [7:0] lim_name;
  logic [5:0] lim_label;
  logic [2:0] pending_status[$];
  int         pinned_status[$];
  int         fail_count = 0;

  logic [7:0] name_bytes[$];
  int         gen_name_lim = 255;
  int         gen_label_lim = 63;
  int         words_sent = 0;
  bit         src_idle_on = 1'b1;
  bit         sink_stall_en = 1'b1;
  int         sink_hold = 0;

  string row_text[ROWS] = '{"", ".", ".a", "a..b", "a*", "a.1", "a.", "abcd.xn--", "ab",
                            "*", "\377"};
  tail_e row_tail[ROWS] = '{END_EMPTY, END_LAST, END_LAST, END_LAST, END_LAST, END_LAST,
                            END_LAST, END_LAST, END_EMPTY, END_BOTH, END_LAST};
  int    row_want[ROWS] = '{ST_BAD_LENGTH, ST_LONE_DOT, ST_LEADING_DOT, ST_DOUBLE_DOT,
                            ST_BAD_CHAR, ST_BAD_LABEL, NO_PIN, NO_PIN, NO_PIN,
                            ST_BAD_LENGTH, ST_BAD_CHAR};

  logic [7:0] phase_name[7]  = '{8'd255, 8'd1, 8'd0, 8'd20, 8'd12, 8'd255, 8'd40};
  logic [7:0] phase_label[7] = '{8'd63, 8'd1, 8'd0, 8'd3, 8'hC5, 8'hFF, 8'd2};

  function automatic logic legal_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == CH_DOT || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] xn_at(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = CH_X;
      3'd1:    c = CH_N;
      default: c = CH_DASH;
    endcase
    return c;
  endfunction

  task automatic scan_char(input logic [7:0] c);
    logic [8:0] nxt;
    nxt = (scan.seen == NAME_SAT) ? NAME_SAT : scan.seen + 9'd1;
    if (scan.seen == 9'd0 && c == CH_DOT) scan.lead_dot = 1'b1;
    if (!legal_char(c)) scan.junk = 1'b1;
    if (c == CH_DOT) begin
      if (scan.scan_fault == ST_VALID) begin
        if (scan.prev_dot) scan.scan_fault = ST_DOUBLE_DOT;
        else if (scan.run > {1'b0, lim_label}) scan.scan_fault = ST_BAD_LABEL;
      end
      scan.run = '0;
      scan.xn_hits = '0;
      scan.tail_bad = 1'b0;
      scan.tail_pos = nxt;
      scan.prev_dot = 1'b1;
    end else begin
      // prefix only advances while every char so far in the label has matched
      if (scan.xn_hits < PREFIX_LEN && scan.run == {4'b0, scan.xn_hits} &&
          c == xn_at(scan.xn_hits)) begin
        scan.xn_hits = scan.xn_hits + 3'd1;
      end
      if (c == CH_DASH || c == CH_UNDER || (c >= "0" && c <= "9")) scan.tail_bad = 1'b1;
      if (scan.run != LABEL_SAT) scan.run = scan.run + 7'd1;
      scan.prev_dot = 1'b0;
    end
    scan.seen = nxt;
  endtask

  function automatic logic [2:0] grade_name();
    logic [2:0] g;
    if (scan.seen == 9'd0 || scan.seen > {1'b0, lim_name}) g = ST_BAD_LENGTH;
    else if (scan.junk) g = ST_BAD_CHAR;
    else if (scan.lead_dot) g = (scan.seen == 9'd1) ? ST_LONE_DOT : ST_LEADING_DOT;
    else if (scan.scan_fault != ST_VALID) g = scan.scan_fault;
    else if (scan.run > {1'b0, lim_label}) g = ST_BAD_LABEL;
    else if (scan.tail_pos > SHORT_LIMIT && scan.xn_hits == PREFIX_LEN) g = ST_VALID;
    else if (scan.tail_bad) g = ST_BAD_LABEL;
    else g = ST_VALID;
    return g;
  endfunction

  always @(posedge clk) begin : check_and_predict
    logic [2:0] want;
    int         pin;
    if (rst) begin
      lim_name = MAX_NAME_RESET;
      lim_label = MAX_LABEL_RESET;
      scan = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_NAME:  lim_name = cfg_data;
          CFG_MAX_LABEL: lim_label = cfg_data[5:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: status word with no name pending: expected none, got %0d",
                   $time, status);
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          if (status !== want) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want, status);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (!empty_name) scan_char(char_code);
        if (empty_name || last) begin
          pin = (pinned_status.size() != 0) ? pinned_status.pop_front() : NO_PIN;
          pending_status.push_back(pin >= 0 ? 3'(pin) : grade_name());
          scan = '0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      result_ready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 99) < 30) begin
      sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic int pick_gap(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_word(input logic [7:0] c, input logic l, input logic e);
    int gap;
    @(negedge clk);
    item_valid <= 1'b1;
    char_code <= c;
    last <= l;
    empty_name <= e;
    do @(posedge clk); while (!item_ready);
    words_sent++;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_name(input tail_e tail, input int pin);
    int n;
    n = name_bytes.size();
    pinned_status.push_back(pin);
    for (int i = 0; i < n; i++) begin
      if (i < n - 1 || tail == END_EMPTY) send_word(name_bytes[i], 1'b0, 1'b0);
      else send_word(name_bytes[i], 1'b1, tail == END_BOTH);
    end
    // a closing empty_name word: its char and last bit are don't-care
    if (tail == END_EMPTY) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic wait_all_status();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limit(input logic [1:0] idx, input logic [7:0] data);
    wait_all_status();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_NAME) gen_name_lim = data;
    else gen_label_lim = data & 8'h3F;
  endtask

  function automatic logic [7:0] pick_host_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    end
    if (r < 76) return CH_X;
    if (r < 80) return CH_N;
    if (r < 88) return CH_DASH;
    if (r < 92) return CH_UNDER;
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic add_label(input int len, input bit top);
    int k;
    k = 0;
    if (top && $urandom_range(0, 3) == 0) begin
      name_bytes.push_back(CH_X);
      name_bytes.push_back(CH_N);
      name_bytes.push_back(CH_DASH);
      name_bytes.push_back(CH_DASH);
      k = 4;
    end
    while (k < len) begin
      name_bytes.push_back(pick_host_char());
      k++;
    end
  endtask

  task automatic make_name(output tail_e tail);
    int kind, labels, len, r, pos;
    name_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) name_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      labels = $urandom_range(1, 4);
      for (int k = 0; k < labels; k++) begin
        if (k > 0) name_bytes.push_back(CH_DOT);
        if ($urandom_range(0, 9) == 0) len = gen_label_lim - 1 + $urandom_range(0, 2);
        else len = $urandom_range(1, 8);
        if (len < 1) len = 1;
        add_label(len, k == labels - 1);
      end
      // broken names: stray dots and bad bytes
      if (kind < 30) begin
        pos = $urandom_range(0, name_bytes.size() - 1);
        case ($urandom_range(0, 4))
          0: name_bytes.insert(pos, CH_DOT);
          1: name_bytes.push_front(CH_DOT);
          2: name_bytes[pos] = 8'($urandom_range(0, 255));
          3: name_bytes.push_back(CH_DOT);
          default: begin
            name_bytes.insert(pos, CH_DOT);
            name_bytes.insert(pos, CH_DOT);
          end
        endcase
      end
    end
    r = $urandom_range(0, 99);
    tail = END_LAST;
    if (r < 4) begin
      name_bytes.delete();
      tail = END_EMPTY;
    end else if (r < 12) begin
      tail = END_EMPTY;
    end else if (r < 16) begin
      tail = END_BOTH;
    end
  endtask

  initial begin : stimulus
    tail_e shape;
    int    goal;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      name_bytes.delete();
      for (int i = 0; i < row_text[r].len(); i++) name_bytes.push_back(row_text[r][i]);
      send_name(row_tail[r], row_want[r]);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 7) begin
        set_limit(CFG_MAX_NAME, phase_name[p]);
        set_limit(CFG_MAX_LABEL, phase_label[p]);
      end else begin
        set_limit(CFG_MAX_NAME, 8'($urandom_range(0, 255)));
        set_limit(CFG_MAX_LABEL, 8'($urandom_range(0, 255)));
      end
      if (p == 0) begin
        // longest legal name, and one long enough to saturate the counters
        name_bytes.delete();
        for (int k = 0; k < 4; k++) begin
          if (k > 0) name_bytes.push_back(CH_DOT);
          add_label(63, 1'b0);
        end
        send_name(END_LAST, NO_PIN);
        name_bytes.delete();
        add_label(130, 1'b0);
        name_bytes.push_back(CH_DOT);
        add_label(389, 1'b0);
        send_name(END_LAST, ST_BAD_LENGTH);
      end
      goal = words_sent + RANDOM_ITEMS / PHASES;
      while (words_sent < goal) begin
        if ($urandom_range(0, 19) == 0) begin
          src_idle_on = $urandom_range(0, 2) != 0;
          sink_stall_en = $urandom_range(0, 2) != 0;
        end
        if ($urandom_range(0, 59) == 0) wait_all_status();
        make_name(shape);
        send_name(shape, NO_PIN);
      end
    end

    wait_all_status();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
